>>> src/iec_pkg.sv
`timescale 1ns / 1ps

package iec_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_RECORD  = 2'd0;
    localparam logic [1:0] OP_FLUSH   = 2'd1;
    localparam logic [1:0] OP_CONNECT = 2'd2;

    // Wire record type bytes.
    localparam logic [7:0] KIND_KEY_REC   = 8'h4B;
    localparam logic [7:0] KIND_MOUSE_REC = 8'h4D;

    // Bit positions inside field_a of a mouse record.
    localparam int NUM_BTN_BITS = 10;
    localparam int BIT_WHEEL    = 10;
    localparam int BIT_HWHEEL   = 11;
    localparam int BIT_ABS      = 12;
    localparam int BIT_VDESK    = 13;

    // Modes of the held move.
    localparam logic [1:0] MODE_REL      = 2'd1;
    localparam logic [1:0] MODE_ABS      = 2'd2;
    localparam logic [1:0] MODE_ABS_DESK = 2'd3;

    // Result slots of one plan, emitted from the lowest set slot upward.
    localparam int NUM_MODS      = 8;
    localparam int SLOT_OLD_MOVE = 0;
    localparam int SLOT_NEW_MOVE = 1;
    localparam int SLOT_BTN0     = 2;
    localparam int SLOT_WHEEL    = SLOT_BTN0 + NUM_BTN_BITS;
    localparam int SLOT_HWHEEL   = SLOT_WHEEL + 1;
    localparam int SLOT_KEY      = SLOT_HWHEEL + 1;
    localparam int SLOT_MOD0     = SLOT_KEY + 1;
    localparam int NUM_SLOTS     = SLOT_MOD0 + NUM_MODS;
    localparam int SLOT_W        = $clog2(NUM_SLOTS);

    typedef enum logic [2:0] {
        EV_KEY,
        EV_REL_MOVE,
        EV_ABS_MOVE,
        EV_BUTTON,
        EV_WHEEL,
        EV_HWHEEL
    } t_event_kind;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         record_kind;
        logic [15:0]        field_a;
        logic [15:0]        field_b;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
    } t_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_move;

    // Everything one input word leaves to be emitted.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        t_move                old_mv;
        t_move                new_mv;
        logic [15:0]          scan;
        logic                 rel;
        logic                 ext;
        logic signed [15:0]   wheel;
    } t_plan;

    typedef struct packed {
        t_event_kind        event_kind;
        logic [15:0]        scan_code;
        logic               key_release;
        logic               key_extended;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               virtual_desk;
        logic [2:0]         button_id;
        logic               button_press;
        logic signed [15:0] wheel_delta;
        logic               last_in_run;
    } t_result;

    // Scan codes of the modifier keys released on connect.
    function automatic logic [15:0] mod_scan(input logic [2:0] idx);
        logic [15:0] v;
        case (idx)
            3'd0:    v = 16'h002A;
            3'd1:    v = 16'h0036;
            3'd2:    v = 16'h001D;
            3'd3:    v = 16'h001D;
            3'd4:    v = 16'h0038;
            3'd5:    v = 16'h0038;
            3'd6:    v = 16'h005B;
            3'd7:    v = 16'h005C;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // Right-hand control and alt and both system keys use the extended prefix.
    function automatic logic mod_ext(input logic [2:0] idx);
        logic v;
        case (idx)
            3'd3, 3'd5, 3'd6, 3'd7: v = 1'b1;
            default:                v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

>>> src/iec_ifs.sv
`timescale 1ns / 1ps

// Channel carrying packed wire records into the block.
interface iec_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [7:0]         record_kind;
    logic [15:0]        field_a;
    logic [15:0]        field_b;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;

    modport source (
        output valid, operation, record_kind, field_a, field_b, delta_x, delta_y,
        input  ready
    );
    modport sink (
        input  valid, operation, record_kind, field_a, field_b, delta_x, delta_y,
        output ready
    );
endinterface

// Channel carrying single input events out of the block.
interface iec_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [15:0]        scan_code;
    logic               key_release;
    logic               key_extended;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               virtual_desk;
    logic [2:0]         button_id;
    logic               button_press;
    logic signed [15:0] wheel_delta;
    logic               last_in_run;

    modport source (
        output valid, event_kind, scan_code, key_release, key_extended, pos_x, pos_y,
               virtual_desk, button_id, button_press, wheel_delta, last_in_run,
        input  ready
    );
    modport sink (
        input  valid, event_kind, scan_code, key_release, key_extended, pos_x, pos_y,
               virtual_desk, button_id, button_press, wheel_delta, last_in_run,
        output ready
    );
endinterface

>>> src/iec_decode.sv
`timescale 1ns / 1ps

// Holds the trailing move and turns one input word into a plan of results.
module iec_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  iec_pkg::t_item i_item,
    output iec_pkg::t_plan o_plan
);
    import iec_pkg::*;

    logic               r_held_valid, n_held_valid;
    logic [1:0]         r_held_mode, n_held_mode;
    logic signed [31:0] r_held_x, n_held_x;
    logic signed [31:0] r_held_y, n_held_y;

    logic [31:0] sext_x, sext_y;
    logic [31:0] abs_x, abs_y;
    logic [1:0]  abs_mode;
    logic        has_step;

    // Add a 16-bit step to a 32-bit sum, clamping at the 32-bit limits.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [15:0] d);
        logic [32:0] s;
        logic [31:0] r;
        s = {a[31], a} + {{17{d[15]}}, d};
        if (s[32] != s[31]) begin
            r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    assign sext_x   = {{16{i_item.delta_x[15]}}, i_item.delta_x};
    assign sext_y   = {{16{i_item.delta_y[15]}}, i_item.delta_y};
    assign abs_x    = {16'h0000, i_item.delta_x};
    assign abs_y    = {16'h0000, i_item.delta_y};
    assign abs_mode = i_item.field_a[BIT_VDESK] ? MODE_ABS_DESK : MODE_ABS;
    assign has_step = (i_item.delta_x != 16'sd0) || (i_item.delta_y != 16'sd0);

    // Next held move and the results this word causes.
    always_comb begin
        n_held_valid = r_held_valid;
        n_held_mode  = r_held_mode;
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        o_plan       = '0;
        o_plan.old_mv = '{mode: r_held_mode, x: r_held_x, y: r_held_y};

        case (i_item.operation)
            OP_RECORD: begin
                if (i_item.record_kind == KIND_KEY_REC) begin
                    o_plan.mask[SLOT_OLD_MOVE] = r_held_valid;
                    o_plan.mask[SLOT_KEY]      = 1'b1;
                    o_plan.scan = i_item.field_a;
                    o_plan.rel  = i_item.field_b[0];
                    o_plan.ext  = i_item.field_b[1];
                    n_held_valid = 1'b0;
                end else if (i_item.record_kind == KIND_MOUSE_REC) begin
                    // The move part: replace, add into, or flush and start over.
                    if (i_item.field_a[BIT_ABS]) begin
                        if (!(r_held_valid && r_held_mode == abs_mode)) begin
                            o_plan.mask[SLOT_OLD_MOVE] = r_held_valid;
                        end
                        n_held_valid = 1'b1;
                        n_held_mode  = abs_mode;
                        n_held_x     = abs_x;
                        n_held_y     = abs_y;
                    end else if (has_step) begin
                        if (r_held_valid && r_held_mode == MODE_REL) begin
                            n_held_x = sat_add(r_held_x, i_item.delta_x);
                            n_held_y = sat_add(r_held_y, i_item.delta_y);
                        end else begin
                            o_plan.mask[SLOT_OLD_MOVE] = r_held_valid;
                            n_held_valid = 1'b1;
                            n_held_mode  = MODE_REL;
                            n_held_x     = sext_x;
                            n_held_y     = sext_y;
                        end
                    end
                    o_plan.new_mv = '{mode: n_held_mode, x: n_held_x, y: n_held_y};
                    // Buttons or wheels flush the move that is now held.
                    if (i_item.field_a[BIT_HWHEEL:0] != '0) begin
                        o_plan.mask[SLOT_NEW_MOVE] = n_held_valid;
                        o_plan.mask[SLOT_BTN0 +: NUM_BTN_BITS] =
                            i_item.field_a[NUM_BTN_BITS-1:0];
                        o_plan.mask[SLOT_WHEEL]  = i_item.field_a[BIT_WHEEL];
                        o_plan.mask[SLOT_HWHEEL] = i_item.field_a[BIT_HWHEEL];
                        o_plan.wheel = i_item.field_b;
                        n_held_valid = 1'b0;
                    end
                end
            end
            OP_FLUSH: begin
                o_plan.mask[SLOT_OLD_MOVE] = r_held_valid;
                n_held_valid = 1'b0;
            end
            OP_CONNECT: begin
                o_plan.mask[SLOT_MOD0 +: NUM_MODS] = '1;
                n_held_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Held move register, updated once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_mode  <= 2'd0;
            r_held_x     <= '0;
            r_held_y     <= '0;
        end else if (i_take) begin
            r_held_valid <= n_held_valid;
            r_held_mode  <= n_held_mode;
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
        end
    end

endmodule

>>> src/iec_emit.sv
`timescale 1ns / 1ps

// Walks the pending slots of a plan and registers one result word per cycle while the output is not stalled.
module iec_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  iec_pkg::t_plan   i_plan,
    input  logic             i_out_ready,
    output logic             o_can_load,
    output logic             o_out_valid,
    output iec_pkg::t_result o_out
);
    import iec_pkg::*;

    logic [NUM_SLOTS-1:0] r_mask;
    t_plan                r_plan;
    logic                 r_out_valid;
    t_result              r_out;

    logic [NUM_SLOTS-1:0] lowest;
    logic [NUM_SLOTS-1:0] rest;
    logic [SLOT_W-1:0]    sel;
    logic [SLOT_W-1:0]    btn_bit;
    logic [SLOT_W-1:0]    mod_idx;
    logic                 issue;
    t_move                mv;
    t_result              n_out;

    // Lowest pending slot and what remains after it.
    assign lowest = r_mask & (~r_mask + 1'b1);
    assign rest   = r_mask & ~lowest;
    assign issue  = (r_mask != '0) && (!r_out_valid || i_out_ready);
    assign o_can_load = (r_mask == '0) || (issue && rest == '0);

    always_comb begin
        sel = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (lowest[i]) begin
                sel = sel | SLOT_W'(i);
            end
        end
    end

    assign btn_bit = sel - SLOT_W'(SLOT_BTN0);
    assign mod_idx = sel - SLOT_W'(SLOT_MOD0);
    assign mv      = (sel == SLOT_W'(SLOT_OLD_MOVE)) ? r_plan.old_mv : r_plan.new_mv;

    // Build the result word for the selected slot.
    always_comb begin
        n_out = '0;
        n_out.last_in_run = (rest == '0);
        case (sel) inside
            SLOT_W'(SLOT_OLD_MOVE), SLOT_W'(SLOT_NEW_MOVE): begin
                n_out.event_kind   = (mv.mode == MODE_REL) ? EV_REL_MOVE : EV_ABS_MOVE;
                n_out.pos_x        = mv.x;
                n_out.pos_y        = mv.y;
                n_out.virtual_desk = (mv.mode == MODE_ABS_DESK);
            end
            [SLOT_W'(SLOT_BTN0):SLOT_W'(SLOT_WHEEL - 1)]: begin
                n_out.event_kind   = EV_BUTTON;
                n_out.button_id    = btn_bit[3:1];
                n_out.button_press = ~btn_bit[0];
            end
            SLOT_W'(SLOT_WHEEL): begin
                n_out.event_kind  = EV_WHEEL;
                n_out.wheel_delta = r_plan.wheel;
            end
            SLOT_W'(SLOT_HWHEEL): begin
                n_out.event_kind  = EV_HWHEEL;
                n_out.wheel_delta = r_plan.wheel;
            end
            SLOT_W'(SLOT_KEY): begin
                n_out.event_kind   = EV_KEY;
                n_out.scan_code    = r_plan.scan;
                n_out.key_release  = r_plan.rel;
                n_out.key_extended = r_plan.ext;
            end
            [SLOT_W'(SLOT_MOD0):SLOT_W'(NUM_SLOTS - 1)]: begin
                n_out.event_kind   = EV_KEY;
                n_out.scan_code    = mod_scan(mod_idx[2:0]);
                n_out.key_release  = 1'b1;
                n_out.key_extended = mod_ext(mod_idx[2:0]);
            end
            default: begin
            end
        endcase
    end

    // Pending slots: a new plan replaces the finished one, else one slot retires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_plan.mask;
        end else if (issue) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_plan <= i_plan;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (issue) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_lowest_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mask != '0 |-> $onehot(lowest))
        else $error("pending slot pick is not one-hot");

    a_load_allowed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("plan loaded over unfinished results");

    a_last_marked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && rest == '0 |=> r_out_valid && r_out.last_in_run)
        else $error("final result of a word not marked last");

    a_key_vs_mods : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mask[SLOT_KEY] |-> r_mask[SLOT_MOD0 +: NUM_MODS] == '0)
        else $error("key word and connect releases mixed in one plan");
`endif

endmodule

>>> src/input_event_coalescer.sv
`timescale 1ns / 1ps
// A taken word's plan is registered in the emit block, and its first result then in the output register.
// Throughput: one result per cycle while the consumer does not stall the single output register;
// a word yields at most 14 results, or none.
// The next word is taken in the cycle its predecessor's last result is registered.
// Reset: i_rst_n low at a clock edge drops the held move, pending results and the output word.

module input_event_coalescer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    iec_in_if.sink           i_in,
    iec_out_if.source        o_out
);
    import iec_pkg::*;

    t_item   item;
    t_plan   plan;
    t_result out_word;
    logic    can_load;
    logic    take;
    logic    out_valid;

    // Gather the input word.
    assign item = '{operation:   i_in.operation,
                    record_kind: i_in.record_kind,
                    field_a:     i_in.field_a,
                    field_b:     i_in.field_b,
                    delta_x:     i_in.delta_x,
                    delta_y:     i_in.delta_y};

    assign i_in.ready = can_load;
    assign take       = i_in.valid && can_load;

    iec_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (item),
        .o_plan  (plan)
    );

    iec_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_plan      (plan),
        .i_out_ready (o_out.ready),
        .o_can_load  (can_load),
        .o_out_valid (out_valid),
        .o_out       (out_word)
    );

    // Drive the output channel.
    assign o_out.valid        = out_valid;
    assign o_out.event_kind   = out_word.event_kind;
    assign o_out.scan_code    = out_word.scan_code;
    assign o_out.key_release  = out_word.key_release;
    assign o_out.key_extended = out_word.key_extended;
    assign o_out.pos_x        = out_word.pos_x;
    assign o_out.pos_y        = out_word.pos_y;
    assign o_out.virtual_desk = out_word.virtual_desk;
    assign o_out.button_id    = out_word.button_id;
    assign o_out.button_press = out_word.button_press;
    assign o_out.wheel_delta  = out_word.wheel_delta;
    assign o_out.last_in_run  = out_word.last_in_run;

endmodule
